// File: hw/rtl/dllc_pkg.sv
// Package for the doubly linked list cursor block.
// Field widths, operation and status codes, FSM states, memory write enables.
// No dependencies.
`default_nettype none
package dllc_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int OP_W         = 3;
  localparam int HANDLE_W     = 32;
  localparam int POS_W        = 8;
  localparam int STATUS_W     = 3;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_LIST   = 3'd1,
    OP_NEXT   = 3'd2,
    OP_PREV   = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_AT_END   = 3'd2,
    ST_AT_START = 3'd3,
    ST_BAD_POS  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_APP_WR,
    S_APP_LINK,
    S_LIST_RD,
    S_MOVE_RD,
    S_MOVE_T,
    S_DEL_RD,
    S_DEL_P,
    S_DEL_N
  } state_t;

  typedef struct packed {
    logic payload;
    logic next_link;
    logic prev_link;
  } mem_we_t;

endpackage
`default_nettype wire

// File: hw/rtl/dllc_mem.sv
// Entry storage: payload, next link and prev link per slot.
// One write port with per-field enables, one registered read port.
// Depends on dllc_pkg.
`default_nettype none
module dllc_mem #(
  parameter int CAPACITY = dllc_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [$clog2(CAPACITY)-1:0]       rd_addr,
  output logic [dllc_pkg::HANDLE_W-1:0]     rd_payload,
  output logic [$clog2(CAPACITY+1)-1:0]     rd_next,
  output logic [$clog2(CAPACITY+1)-1:0]     rd_prev,
  input  dllc_pkg::mem_we_t                 we,
  input  logic [$clog2(CAPACITY)-1:0]       wr_addr,
  input  logic [dllc_pkg::HANDLE_W-1:0]     wr_payload,
  input  logic [$clog2(CAPACITY+1)-1:0]     wr_next,
  input  logic [$clog2(CAPACITY+1)-1:0]     wr_prev
);
  import dllc_pkg::*;

  localparam int SW = $clog2(CAPACITY + 1);

  logic [HANDLE_W-1:0] payload_mem [CAPACITY];
  logic [SW-1:0]       next_mem    [CAPACITY];
  logic [SW-1:0]       prev_mem    [CAPACITY];

  always_ff @(posedge clk) begin
    if (we.payload) begin
      payload_mem[wr_addr] <= wr_payload;
    end
    if (we.next_link) begin
      next_mem[wr_addr] <= wr_next;
    end
    if (we.prev_link) begin
      prev_mem[wr_addr] <= wr_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_payload <= payload_mem[rd_addr];
      rd_next    <= next_mem[rd_addr];
      rd_prev    <= prev_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/doubly_linked_list_cursor.sv
// Doubly linked list with a play cursor: sequencer, head/tail/cursor registers,
// free map, and the result register. Depends on dllc_pkg and dllc_mem.
//
// One operation is taken per transaction while busy is low; busy stays high
// until the operation's last memory write or last result is done. Results are
// registered and appear in the cycle after they are produced, each for one cycle
// with result_valid; the receiver must take them. All link walks go through the
// single read port of the entry memory, one entry per cycle. Append scans the
// slots for a free one, writes the new entry and, if the list was not empty,
// links the old tail to it; list emits one result per entry with no gaps;
// delete walks to position p, then relinks the previous and the next entry.
`default_nettype none
module doubly_linked_list_cursor #(
  parameter int CAPACITY = dllc_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [dllc_pkg::OP_W-1:0]         operation,
  input  logic [dllc_pkg::HANDLE_W-1:0]     song_handle,
  input  logic [dllc_pkg::POS_W-1:0]        position,
  output logic                              result_valid,
  output logic [dllc_pkg::STATUS_W-1:0]     status,
  output logic [dllc_pkg::HANDLE_W-1:0]     entry_handle,
  output logic                              last
);
  import dllc_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int CW = (SW > POS_W) ? SW : POS_W;
  localparam logic [SW-1:0] NULL_SLOT = SW'(CAPACITY);
  localparam logic [SW-1:0] LAST_IDX  = SW'(CAPACITY - 1);

  function automatic logic slot_ok(input logic [SW-1:0] s);
    return s < NULL_SLOT;
  endfunction

  state_t state, state_next;

  logic [CAPACITY-1:0] free_map, free_map_next;
  logic [SW-1:0]       head, head_next;
  logic [SW-1:0]       tail, tail_next;
  logic [SW-1:0]       cursor, cursor_next;
  logic [SW-1:0]       count, count_next;
  logic [SW-1:0]       cur, cur_next;
  logic [SW-1:0]       p_slot, p_slot_next;
  logic [SW-1:0]       n_slot, n_slot_next;
  logic [SW-1:0]       walk, walk_next;
  logic [HANDLE_W-1:0] handle_q, handle_q_next;
  logic [AW-1:0]       pos_q, pos_q_next;
  logic                move_fwd, move_fwd_next;

  logic                emit;
  status_t             emit_status;
  logic [HANDLE_W-1:0] emit_handle;
  logic                emit_last;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [HANDLE_W-1:0] rd_payload;
  logic [SW-1:0]       rd_next;
  logic [SW-1:0]       rd_prev;
  mem_we_t             we;
  logic [AW-1:0]       wr_addr;
  logic [HANDLE_W-1:0] wr_payload;
  logic [SW-1:0]       wr_next;
  logic [SW-1:0]       wr_prev;

  logic                accept;
  logic                bad_pos;
  logic                list_last;
  logic [SW-1:0]       move_tgt;

  dllc_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk        (clk),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_payload (rd_payload),
    .rd_next    (rd_next),
    .rd_prev    (rd_prev),
    .we         (we),
    .wr_addr    (wr_addr),
    .wr_payload (wr_payload),
    .wr_next    (wr_next),
    .wr_prev    (wr_prev)
  );

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign bad_pos   = CW'(position) >= CW'(count);
  assign list_last = !slot_ok(rd_next) || (walk == LAST_IDX);
  assign move_tgt  = move_fwd ? rd_next : rd_prev;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op_t'(operation))
            OP_APPEND: state_next = (count == NULL_SLOT) ? S_IDLE : S_SCAN;
            OP_LIST:   state_next = slot_ok(head) ? S_LIST_RD : S_IDLE;
            OP_NEXT, OP_PREV: state_next = slot_ok(cursor) ? S_MOVE_RD : S_IDLE;
            OP_DELETE: state_next = (slot_ok(head) && !bad_pos) ? S_DEL_RD : S_IDLE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN:     if (free_map[walk[AW-1:0]]) state_next = S_APP_WR;
      S_APP_WR:   state_next = slot_ok(tail) ? S_APP_LINK : S_IDLE;
      S_APP_LINK: state_next = S_IDLE;
      S_LIST_RD:  if (list_last) state_next = S_IDLE;
      S_MOVE_RD:  state_next = slot_ok(move_tgt) ? S_MOVE_T : S_IDLE;
      S_MOVE_T:   state_next = S_IDLE;
      S_DEL_RD:   if (walk[AW-1:0] == pos_q) state_next = S_DEL_P;
      S_DEL_P:    state_next = S_DEL_N;
      S_DEL_N:    state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    free_map_next = free_map;
    head_next     = head;
    tail_next     = tail;
    cursor_next   = cursor;
    count_next    = count;
    cur_next      = cur;
    p_slot_next   = p_slot;
    n_slot_next   = n_slot;
    walk_next     = walk;
    handle_q_next = handle_q;
    pos_q_next    = pos_q;
    move_fwd_next = move_fwd;
    emit          = 1'b0;
    emit_status   = ST_OK;
    emit_handle   = '0;
    emit_last     = 1'b1;
    rd_en         = 1'b0;
    rd_addr       = cur[AW-1:0];
    we            = '0;
    wr_addr       = cur[AW-1:0];
    wr_payload    = handle_q;
    wr_next       = NULL_SLOT;
    wr_prev       = tail;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          handle_q_next = song_handle;
          pos_q_next    = position[AW-1:0];
          move_fwd_next = (op_t'(operation) == OP_NEXT);
          walk_next     = '0;
          unique case (op_t'(operation))
            OP_APPEND: begin
              if (count == NULL_SLOT) begin
                emit        = 1'b1;
                emit_status = ST_FULL;
              end
            end
            OP_LIST: begin
              if (slot_ok(head)) begin
                rd_en    = 1'b1;
                rd_addr  = head[AW-1:0];
                cur_next = head;
              end else begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end
            end
            OP_NEXT, OP_PREV: begin
              if (slot_ok(cursor)) begin
                rd_en    = 1'b1;
                rd_addr  = cursor[AW-1:0];
                cur_next = cursor;
              end else begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end
            end
            OP_DELETE: begin
              if (!slot_ok(head)) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else if (bad_pos) begin
                emit        = 1'b1;
                emit_status = ST_BAD_POS;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = head[AW-1:0];
                cur_next = head;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (free_map[walk[AW-1:0]]) begin
          cur_next = walk;
        end else begin
          walk_next = walk + 1'b1;
        end
      end
      S_APP_WR: begin
        we                         = '{payload: 1'b1, next_link: 1'b1, prev_link: 1'b1};
        wr_addr                    = cur[AW-1:0];
        wr_payload                 = handle_q;
        wr_prev                    = tail;
        wr_next                    = NULL_SLOT;
        free_map_next[cur[AW-1:0]] = 1'b0;
        tail_next                  = cur;
        p_slot_next                = tail;
        count_next                 = count + 1'b1;
        if (!slot_ok(tail)) begin
          head_next = cur;
        end
        if (!slot_ok(cursor)) begin
          cursor_next = slot_ok(tail) ? head : cur;
        end
        emit        = 1'b1;
        emit_handle = handle_q;
      end
      S_APP_LINK: begin
        we.next_link = 1'b1;
        wr_addr      = p_slot[AW-1:0];
        wr_next      = cur;
      end
      S_LIST_RD: begin
        emit        = 1'b1;
        emit_handle = rd_payload;
        emit_last   = list_last;
        if (!list_last) begin
          rd_en     = 1'b1;
          rd_addr   = rd_next[AW-1:0];
          walk_next = walk + 1'b1;
        end
      end
      S_MOVE_RD: begin
        if (slot_ok(move_tgt)) begin
          cursor_next = move_tgt;
          rd_en       = 1'b1;
          rd_addr     = move_tgt[AW-1:0];
        end else begin
          emit        = 1'b1;
          emit_status = move_fwd ? ST_AT_END : ST_AT_START;
          emit_handle = rd_payload;
        end
      end
      S_MOVE_T: begin
        emit        = 1'b1;
        emit_handle = rd_payload;
      end
      S_DEL_RD: begin
        if (walk[AW-1:0] == pos_q) begin
          emit                       = 1'b1;
          emit_handle                = rd_payload;
          p_slot_next                = rd_prev;
          n_slot_next                = rd_next;
          free_map_next[cur[AW-1:0]] = 1'b1;
          count_next                 = count - 1'b1;
          if (cursor == cur) begin
            cursor_next = NULL_SLOT;
          end
          if (!slot_ok(rd_prev)) begin
            head_next = rd_next;
          end
          if (!slot_ok(rd_next)) begin
            tail_next = rd_prev;
          end
        end else begin
          cur_next  = rd_next;
          walk_next = walk + 1'b1;
          rd_en     = 1'b1;
          rd_addr   = rd_next[AW-1:0];
        end
      end
      S_DEL_P: begin
        if (slot_ok(p_slot)) begin
          we.next_link = 1'b1;
          wr_addr      = p_slot[AW-1:0];
          wr_next      = n_slot;
        end
      end
      S_DEL_N: begin
        if (slot_ok(n_slot)) begin
          we.prev_link = 1'b1;
          wr_addr      = n_slot[AW-1:0];
          wr_prev      = p_slot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_map     <= '1;
      head         <= NULL_SLOT;
      tail         <= NULL_SLOT;
      cursor       <= NULL_SLOT;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      free_map     <= free_map_next;
      head         <= head_next;
      tail         <= tail_next;
      cursor       <= cursor_next;
      count        <= count_next;
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    p_slot   <= p_slot_next;
    n_slot   <= n_slot_next;
    walk     <= walk_next;
    handle_q <= handle_q_next;
    pos_q    <= pos_q_next;
    move_fwd <= move_fwd_next;
    if (emit) begin
      status       <= emit_status;
      entry_handle <= emit_handle;
      last         <= emit_last;
    end
  end

  a_head_count: assert property (@(posedge clk) disable iff (rst)
    (head == NULL_SLOT) == (count == '0))
    else $error("head and entry count disagree");

  a_cursor_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (cursor == NULL_SLOT))
    else $error("cursor set on empty list");

  a_list_burst: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |=> result_valid)
    else $error("gap inside a multi-result transaction");

  a_full: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_APPEND) && (count == NULL_SLOT))
      |=> (result_valid && (status == ST_FULL)))
    else $error("append on full list not flagged");

endmodule
`default_nettype wire
